// ===== src/bgr2yuv_pkg.sv =====
// Shared types, constants and coefficients for the BGR to YUV 4:2:0 pixel stream.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package bgr2yuv_pkg;

	localparam int MAX_DIMENSION = 4096;
	localparam int COUNT_W = $clog2(MAX_DIMENSION);
	localparam int SIZE_W = 13;
	localparam int INDEX_W = 8;
	localparam int PIX_W = 8;

	localparam logic [INDEX_W-1:0] REG_FRAME_WIDTH = INDEX_W'(0);
	localparam logic [INDEX_W-1:0] REG_FRAME_HEIGHT = INDEX_W'(1);

	localparam logic [SIZE_W-1:0] FRAME_WIDTH_RESET = SIZE_W'(1920);
	localparam logic [SIZE_W-1:0] FRAME_HEIGHT_RESET = SIZE_W'(1080);

	// BT.601 integer coefficients
	localparam int Y_R = 66;
	localparam int Y_G = 129;
	localparam int Y_B = 25;
	localparam int U_R = -38;
	localparam int U_G = -74;
	localparam int U_B = 112;
	localparam int V_R = 112;
	localparam int V_G = -94;
	localparam int V_B = -18;
	localparam int ROUND = 128;
	localparam logic [PIX_W-1:0] LUMA_BIAS = PIX_W'(16);
	localparam logic [PIX_W-1:0] CHROMA_BIAS = PIX_W'(128);

	typedef enum logic [1:0] {
		CHROMA_NONE = 2'd0,
		CHROMA_U    = 2'd1,
		CHROMA_V    = 2'd2
	} chroma_kind_t;

	typedef struct packed {
		chroma_kind_t kind;
		logic         frame_end;
	} pos_t;

	typedef struct packed {
		logic [PIX_W-1:0] luma;
		logic [PIX_W-1:0] chroma;
		chroma_kind_t     kind;
		logic             frame_end;
	} result_t;

	// last valid index for a configured size: zero acts as one, oversize clamps
	function automatic logic [COUNT_W-1:0] last_index(input logic [SIZE_W-1:0] size);
		logic [COUNT_W-1:0] idx;
		if (size == '0) begin
			idx = '0;
		end else if (int'(size) > MAX_DIMENSION) begin
			idx = COUNT_W'(MAX_DIMENSION - 1);
		end else begin
			idx = COUNT_W'(int'(size) - 1);
		end
		return idx;
	endfunction

endpackage

// ===== src/bgr2yuv_position.sv =====
// Frame size registers and column/row position counters.
// Depends on bgr2yuv_pkg.
`timescale 1ns / 1ps

module bgr2yuv_position (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [bgr2yuv_pkg::INDEX_W-1:0]  cfg_index,
	input  logic [bgr2yuv_pkg::SIZE_W-1:0]   cfg_data,
	input  logic                              advance,
	output bgr2yuv_pkg::pos_t                 pos
);
	import bgr2yuv_pkg::*;

	logic [SIZE_W-1:0]  frame_width_q;
	logic [SIZE_W-1:0]  frame_height_q;
	logic [COUNT_W-1:0] column_q;
	logic [COUNT_W-1:0] row_q;
	logic               line_end;
	logic               last_row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q <= FRAME_WIDTH_RESET;
			frame_height_q <= FRAME_HEIGHT_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_FRAME_WIDTH: frame_width_q <= cfg_data;
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign line_end = column_q >= last_index(frame_width_q);
	assign last_row = row_q >= last_index(frame_height_q);

	always_comb begin
		pos.frame_end = line_end && last_row;
		if (column_q[0]) begin
			pos.kind = CHROMA_NONE;
		end else if (row_q[0]) begin
			pos.kind = CHROMA_V;
		end else begin
			pos.kind = CHROMA_U;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= '0;
			row_q <= '0;
		end else if (advance) begin
			if (line_end) begin
				column_q <= '0;
				row_q <= last_row ? '0 : row_q + COUNT_W'(1);
			end else begin
				column_q <= column_q + COUNT_W'(1);
			end
		end
	end

endmodule

// ===== src/bgr2yuv_convert.sv =====
// Integer BT.601 color conversion of one registered pixel to a result item.
// Depends on bgr2yuv_pkg.
`timescale 1ns / 1ps

module bgr2yuv_convert (
	input  logic [bgr2yuv_pkg::PIX_W-1:0] blue,
	input  logic [bgr2yuv_pkg::PIX_W-1:0] green,
	input  logic [bgr2yuv_pkg::PIX_W-1:0] red,
	input  bgr2yuv_pkg::pos_t             pos,
	output bgr2yuv_pkg::result_t          result
);
	import bgr2yuv_pkg::*;

	localparam int SUM_W = 18;

	logic signed [SUM_W-1:0] r_x;
	logic signed [SUM_W-1:0] g_x;
	logic signed [SUM_W-1:0] b_x;
	logic signed [SUM_W-1:0] y_sum;
	logic signed [SUM_W-1:0] u_sum;
	logic signed [SUM_W-1:0] v_sum;

	assign r_x = SUM_W'(signed'({1'b0, red}));
	assign g_x = SUM_W'(signed'({1'b0, green}));
	assign b_x = SUM_W'(signed'({1'b0, blue}));

	assign y_sum = SUM_W'(Y_R) * r_x + SUM_W'(Y_G) * g_x + SUM_W'(Y_B) * b_x + SUM_W'(ROUND);
	assign u_sum = SUM_W'(U_R) * r_x + SUM_W'(U_G) * g_x + SUM_W'(U_B) * b_x + SUM_W'(ROUND);
	assign v_sum = SUM_W'(V_R) * r_x + SUM_W'(V_G) * g_x + SUM_W'(V_B) * b_x + SUM_W'(ROUND);

	// floor shift by 8, then bias, modulo 256
	always_comb begin
		result.luma = y_sum[15:8] + LUMA_BIAS;
		result.kind = pos.kind;
		result.frame_end = pos.frame_end;
		case (pos.kind)
			CHROMA_U: result.chroma = u_sum[15:8] + CHROMA_BIAS;
			CHROMA_V: result.chroma = v_sum[15:8] + CHROMA_BIAS;
			default: result.chroma = '0;
		endcase
	end

endmodule

// ===== src/bgr_to_yuv420_pixel_stream.sv =====
// Pipeline: pixel transfer, input register, result register, then result transfer.
// Throughput: one pixel per cycle, bounded by the result_ready side only.
// Reset: arst_n clears counters and pipeline valids; frame_width returns to 1920 and
// frame_height to 1080. Configuration writes are always ready.
// Depends on bgr2yuv_pkg, bgr2yuv_position, bgr2yuv_convert.
`timescale 1ns / 1ps

module bgr_to_yuv420_pixel_stream (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [bgr2yuv_pkg::INDEX_W-1:0]  cfg_index,
	input  logic [bgr2yuv_pkg::SIZE_W-1:0]   cfg_data,
	input  logic                              pixel_valid,
	output logic                              pixel_ready,
	input  logic [bgr2yuv_pkg::PIX_W-1:0]    blue,
	input  logic [bgr2yuv_pkg::PIX_W-1:0]    green,
	input  logic [bgr2yuv_pkg::PIX_W-1:0]    red,
	output logic                              result_valid,
	input  logic                              result_ready,
	output logic [bgr2yuv_pkg::PIX_W-1:0]    luma,
	output logic [bgr2yuv_pkg::PIX_W-1:0]    chroma,
	output logic [1:0]                        chroma_kind,
	output logic                              frame_end
);
	import bgr2yuv_pkg::*;

	logic             valid_s1;
	logic             valid_s2;
	logic             advance_s2;
	logic             pixel_xfer;
	pos_t             pos;
	pos_t             pos_s1;
	logic [PIX_W-1:0] blue_s1;
	logic [PIX_W-1:0] green_s1;
	logic [PIX_W-1:0] red_s1;
	result_t          result;
	result_t          result_s2;

	assign cfg_ready = 1'b1;
	assign advance_s2 = !valid_s2 || result_ready;
	assign pixel_ready = !valid_s1 || advance_s2;
	assign pixel_xfer = pixel_valid && pixel_ready;

	bgr2yuv_position u_position (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.advance   (pixel_xfer),
		.pos       (pos)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pixel_ready) begin
			valid_s1 <= pixel_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pixel_xfer) begin
			blue_s1 <= blue;
			green_s1 <= green;
			red_s1 <= red;
			pos_s1 <= pos;
		end
	end

	bgr2yuv_convert u_convert (
		.blue   (blue_s1),
		.green  (green_s1),
		.red    (red_s1),
		.pos    (pos_s1),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s2 && valid_s1) begin
			result_s2 <= result;
		end
	end

	assign result_valid = valid_s2;
	assign luma = result_s2.luma;
	assign chroma = result_s2.chroma;
	assign chroma_kind = result_s2.kind;
	assign frame_end = result_s2.frame_end;

endmodule

// ===== tb/sv/bgr_to_yuv420_pixel_stream_checker.sv =====
// Checker for the BGR to YUV 4:2:0 pixel stream: watches the register, pixel and result
// channels, predicts each result and compares it field by field. Depends on bgr2yuv_pkg.
`timescale 1ns / 1ps

module bgr_to_yuv420_pixel_stream_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	input  logic                             cfg_ready,
	input  logic [bgr2yuv_pkg::INDEX_W-1:0] cfg_index,
	input  logic [bgr2yuv_pkg::SIZE_W-1:0]  cfg_data,
	input  logic                             pixel_valid,
	input  logic                             pixel_ready,
	input  logic [bgr2yuv_pkg::PIX_W-1:0]   blue,
	input  logic [bgr2yuv_pkg::PIX_W-1:0]   green,
	input  logic [bgr2yuv_pkg::PIX_W-1:0]   red,
	input  logic                             result_valid,
	input  logic                             result_ready,
	input  logic [bgr2yuv_pkg::PIX_W-1:0]   luma,
	input  logic [bgr2yuv_pkg::PIX_W-1:0]   chroma,
	input  logic [1:0]                       chroma_kind,
	input  logic                             frame_end,
	output int                               mismatch_count,
	output int                               yuv_outstanding
);
	import bgr2yuv_pkg::*;

	logic [SIZE_W-1:0] width_reg;
	logic [SIZE_W-1:0] height_reg;
	int                column;
	int                row;
	result_t           predicted_yuv[$];

	// last column or row index for a programmed size
	function automatic int last_position(input logic [SIZE_W-1:0] size);
		if (size == '0) begin
			return 0;
		end
		if (int'(size) > MAX_DIMENSION) begin
			return MAX_DIMENSION - 1;
		end
		return int'(size) - 1;
	endfunction

	function automatic logic [PIX_W-1:0] floor_scale(input int sum, input int bias);
		return PIX_W'((sum >>> 8) + bias);
	endfunction

	function automatic result_t bt601_convert(input logic [PIX_W-1:0] b, input logic [PIX_W-1:0] g,
			input logic [PIX_W-1:0] r, input int col, input int line);
		result_t res;
		int      bv;
		int      gv;
		int      rv;
		bv = int'(b);
		gv = int'(g);
		rv = int'(r);
		res.luma = floor_scale(66 * rv + 129 * gv + 25 * bv + 128, 16);
		res.chroma = '0;
		res.kind = CHROMA_NONE;
		if (col % 2 == 0) begin
			if (line % 2 == 0) begin
				res.chroma = floor_scale(-38 * rv - 74 * gv + 112 * bv + 128, 128);
				res.kind = CHROMA_U;
			end else begin
				res.chroma = floor_scale(112 * rv - 94 * gv - 18 * bv + 128, 128);
				res.kind = CHROMA_V;
			end
		end
		res.frame_end = (col >= last_position(width_reg)) && (line >= last_position(height_reg));
		return res;
	endfunction

	initial begin
		mismatch_count = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			width_reg = FRAME_WIDTH_RESET;
			height_reg = FRAME_HEIGHT_RESET;
			column = 0;
			row = 0;
			predicted_yuv.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_FRAME_WIDTH: begin
						width_reg = cfg_data;
					end
					REG_FRAME_HEIGHT: begin
						height_reg = cfg_data;
					end
					default: begin
					end
				endcase
			end
			if (result_valid && result_ready) begin
				if (predicted_yuv.size() == 0) begin
					mismatch_count++;
					$error("result transfer with no pixel outstanding: luma %0d chroma %0d",
						luma, chroma);
				end else begin
					want = predicted_yuv.pop_front();
					if (luma !== want.luma) begin
						mismatch_count++;
						$error("luma: expected %0d, actual %0d", want.luma, luma);
					end
					if (chroma !== want.chroma) begin
						mismatch_count++;
						$error("chroma: expected %0d, actual %0d", want.chroma, chroma);
					end
					if (chroma_kind !== want.kind) begin
						mismatch_count++;
						$error("chroma_kind: expected %0d, actual %0d", want.kind, chroma_kind);
					end
					if (frame_end !== want.frame_end) begin
						mismatch_count++;
						$error("frame_end: expected %0d, actual %0d", want.frame_end, frame_end);
					end
				end
			end
			if (pixel_valid && pixel_ready) begin
				predicted_yuv.push_back(bt601_convert(blue, green, red, column, row));
				if (column >= last_position(width_reg)) begin
					column = 0;
					row = (row >= last_position(height_reg)) ? 0 : row + 1;
				end else begin
					column++;
				end
			end
		end
		yuv_outstanding = predicted_yuv.size();
	end

endmodule

// ===== tb/sv/bgr_to_yuv420_pixel_stream_tb.sv =====
// Testbench top for the BGR to YUV 4:2:0 pixel stream: clock, reset, register writes,
// pixel stimulus and result back-pressure. Depends on bgr2yuv_pkg and the checker.
`timescale 1ns / 1ps

module bgr_to_yuv420_pixel_stream_tb;
	import bgr2yuv_pkg::*;

	localparam logic [INDEX_W-1:0] REG_SPARE = INDEX_W'(2);
	localparam logic [INDEX_W-1:0] REG_LAST = '1;
	localparam int PIXEL_TARGET = 1750;
	localparam int BACKLOG_HOLD = 300;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [INDEX_W-1:0] cfg_index = '0;
	logic [SIZE_W-1:0]  cfg_data = '0;
	logic               pixel_valid = 1'b0;
	logic               pixel_ready;
	logic [PIX_W-1:0]   blue = '0;
	logic [PIX_W-1:0]   green = '0;
	logic [PIX_W-1:0]   red = '0;
	logic               result_valid;
	logic               result_ready = 1'b0;
	logic [PIX_W-1:0]   luma;
	logic [PIX_W-1:0]   chroma;
	logic [1:0]         chroma_kind;
	logic               frame_end;
	int                 mismatch_count;
	int                 yuv_outstanding;

	bit                 steady = 1'b0;
	bit                 backlog_req = 1'b0;
	int                 pixels_sent = 0;

	bgr_to_yuv420_pixel_stream i_dut (.*);

	bgr_to_yuv420_pixel_stream_checker i_checker (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#3_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	// result side: random stalls outside steady phases, one long hold to back up the pipeline
	initial begin
		int hold_left;
		bit hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (backlog_req && !hold_done) begin
				hold_left = BACKLOG_HOLD;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ready <= 1'b0;
			end else if (steady) begin
				result_ready <= 1'b1;
			end else begin
				result_ready <= ($urandom_range(99) >= 37);
			end
		end
	end

	task automatic write_reg(input logic [INDEX_W-1:0] index, input logic [SIZE_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic push_pixel(input logic [PIX_W-1:0] b, input logic [PIX_W-1:0] g,
			input logic [PIX_W-1:0] r);
		while (!steady && $urandom_range(99) < 37) begin
			@(negedge clk);
			pixel_valid <= 1'b0;
		end
		@(negedge clk);
		pixel_valid <= 1'b1;
		blue <= b;
		green <= g;
		red <= r;
		do @(posedge clk); while (!pixel_ready);
		pixels_sent++;
	endtask

	// drop valid and wait for every outstanding result
	task automatic settle();
		@(negedge clk);
		pixel_valid <= 1'b0;
		wait (yuv_outstanding == 0);
	endtask

	function automatic logic [PIX_W-1:0] rand_channel();
		if ($urandom_range(7) == 0) begin
			return $urandom_range(1) ? '1 : '0;
		end
		return PIX_W'($urandom);
	endfunction

	function automatic logic [SIZE_W-1:0] pick_size();
		case ($urandom_range(15))
			0: return '0;
			1: return SIZE_W'($urandom_range(8191));
			2: return SIZE_W'($urandom_range(9, 64));
			default: return SIZE_W'($urandom_range(1, 8));
		endcase
	endfunction

	function automatic int usable_size(input logic [SIZE_W-1:0] size);
		if (size == '0) begin
			return 1;
		end
		return (int'(size) > MAX_DIMENSION) ? MAX_DIMENSION : int'(size);
	endfunction

	initial begin
		logic [SIZE_W-1:0] cur_width;
		logic [SIZE_W-1:0] cur_height;
		int                area;
		int                count;
		cur_width = FRAME_WIDTH_RESET;
		cur_height = FRAME_HEIGHT_RESET;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset frame size
		push_pixel(8'h00, 8'h00, 8'h00);
		push_pixel(8'hFF, 8'hFF, 8'hFF);
		push_pixel(8'h80, 8'h80, 8'h80);
		settle();

		// shrink mid-line: column three ends the line at once
		write_reg(REG_FRAME_WIDTH, SIZE_W'(4));
		write_reg(REG_FRAME_HEIGHT, SIZE_W'(2));
		push_pixel(8'hFF, 8'h00, 8'h00);
		push_pixel(8'h00, 8'h00, 8'hFF);
		push_pixel(8'h00, 8'hFF, 8'h00);
		push_pixel(8'hFF, 8'h00, 8'hFF);
		push_pixel(8'h00, 8'hFF, 8'hFF);
		push_pixel(8'hFF, 8'h00, 8'h00);
		push_pixel(8'h00, 8'hFF, 8'hFF);
		push_pixel(8'hFF, 8'hFF, 8'h00);
		push_pixel(8'h00, 8'h00, 8'h00);
		settle();

		// zero sizes act as one
		write_reg(REG_FRAME_WIDTH, '0);
		write_reg(REG_FRAME_HEIGHT, '0);
		push_pixel(8'hFF, 8'hFF, 8'hFF);
		push_pixel(8'h01, 8'h02, 8'h03);
		settle();

		// oversize clamps, then shrink width and height mid-frame
		write_reg(REG_FRAME_WIDTH, '1);
		write_reg(REG_FRAME_HEIGHT, SIZE_W'(MAX_DIMENSION + 1));
		repeat (4) push_pixel(rand_channel(), rand_channel(), rand_channel());
		settle();
		write_reg(REG_FRAME_WIDTH, SIZE_W'(2));
		push_pixel(8'h10, 8'hEF, 8'h7F);
		push_pixel(8'hFF, 8'h00, 8'hFF);
		settle();
		write_reg(REG_FRAME_HEIGHT, '0);
		push_pixel(8'h00, 8'hFF, 8'h00);
		push_pixel(8'h55, 8'hAA, 8'h55);
		settle();

		// unmapped indexes are ignored
		write_reg(REG_SPARE, '1);
		write_reg(REG_LAST, SIZE_W'(5));
		push_pixel(8'h33, 8'hCC, 8'h99);
		settle();

		// back up the pipeline behind a long result stall
		write_reg(REG_FRAME_WIDTH, SIZE_W'(16));
		write_reg(REG_FRAME_HEIGHT, SIZE_W'(16));
		cur_width = SIZE_W'(16);
		cur_height = SIZE_W'(16);
		steady = 1'b1;
		backlog_req = 1'b1;
		repeat (200) push_pixel(rand_channel(), rand_channel(), rand_channel());
		steady = 1'b0;

		while (pixels_sent < PIXEL_TARGET) begin
			settle();
			steady = (pixels_sent > 800 && pixels_sent < 1100);
			if ($urandom_range(1)) begin
				cur_width = pick_size();
				write_reg(REG_FRAME_WIDTH, cur_width);
			end
			if ($urandom_range(3) != 0) begin
				cur_height = pick_size();
				write_reg(REG_FRAME_HEIGHT, cur_height);
			end
			if ($urandom_range(9) == 0) begin
				write_reg(INDEX_W'($urandom_range(REG_SPARE, REG_LAST)), SIZE_W'($urandom));
			end
			area = usable_size(cur_width) * usable_size(cur_height);
			if (area <= 48) begin
				count = area * $urandom_range(1, 3) + $urandom_range(0, 3);
			end else begin
				count = $urandom_range(1, 48);
			end
			repeat (count) push_pixel(rand_channel(), rand_channel(), rand_channel());
		end
		steady = 1'b0;

		settle();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
src/bgr2yuv_pkg.sv
src/bgr2yuv_position.sv
src/bgr2yuv_convert.sv
src/bgr_to_yuv420_pixel_stream.sv
tb/sv/bgr_to_yuv420_pixel_stream_checker.sv
tb/sv/bgr_to_yuv420_pixel_stream_tb.sv
